FILE: rtl/ctla_pkg.sv
// Shared types and constants for the callsign to link-address encoder.
package ctla_pkg;

   // Callsign geometry and fixed byte values
   localparam int unsigned CALL_CHARS = 6;
   localparam int unsigned COUNT_W = $clog2(CALL_CHARS + 1);
   localparam int unsigned CALL_W = 8 * CALL_CHARS;
   localparam logic [7:0] PAD_BYTE = 8'h40;
   localparam logic [7:0] STATION_BASE = 8'h60;
   localparam logic [4:0] STATION_MAX = 5'd15;
   localparam logic [4:0] ACCUM_SAT = 5'd16;
   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   // Character codes
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_DASH = 8'h2D;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [CALL_W-1:0] callsign_bytes;
      logic [7:0]        station_byte;
      logic              bad_text;
   } rsp_type;

   typedef enum logic [2:0] {
      KIND_NUL,
      KIND_DASH,
      KIND_PLUS,
      KIND_WHITE,
      KIND_DIGIT,
      KIND_OTHER
   } kind_type;

   // Classified item passed from front to back
   typedef struct packed {
      kind_type   kind;
      logic [7:0] call_byte;
      logic [3:0] digit;
      logic       is_last;
   } class_type;

   typedef enum logic [1:0] {
      PH_CALL,
      PH_SPACE,
      PH_DIGITS,
      PH_DONE
   } phase_type;

endpackage

FILE: rtl/ctla_front.sv
// Front end: accepts text items and classifies each character.
module ctla_front (
   input  ctla_pkg::req_type   req_item,
   input  logic                push,
   input  logic                queue_full,
   output logic                full,
   output logic                queue_push,
   output ctla_pkg::class_type queue_item
);
   import ctla_pkg::*;

   logic [7:0] upper_code;

   // Accept whenever the queue has room
   assign full = queue_full;
   assign queue_push = push && !queue_full;

   // Fold a..z to upper case
   assign upper_code = (req_item.char_code inside {[CH_LOWER_A:CH_LOWER_Z]}) ?
                       req_item.char_code - CASE_OFFSET : req_item.char_code;

   // Classify the character
   always_comb begin
      queue_item.call_byte = {upper_code[6:0], 1'b0};
      queue_item.digit = req_item.char_code[3:0];
      queue_item.is_last = req_item.is_last;
      if (req_item.char_code == CH_NUL) begin
         queue_item.kind = KIND_NUL;
      end else if (req_item.char_code == CH_DASH) begin
         queue_item.kind = KIND_DASH;
      end else if (req_item.char_code == CH_PLUS) begin
         queue_item.kind = KIND_PLUS;
      end else if (req_item.char_code == CH_SPACE ||
                   req_item.char_code inside {[CH_TAB:CH_CR]}) begin
         queue_item.kind = KIND_WHITE;
      end else if (req_item.char_code inside {[CH_ZERO:CH_NINE]}) begin
         queue_item.kind = KIND_DIGIT;
      end else begin
         queue_item.kind = KIND_OTHER;
      end
   end

endmodule

FILE: rtl/ctla_queue.sv
// Short item queue between the classifier and the parser.
module ctla_queue #(
   parameter int unsigned DEPTH = ctla_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ctla_pkg::class_type push_item,
   output logic                full,
   input  logic                pop,
   output logic                valid,
   output ctla_pkg::class_type head_item
);
   import ctla_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   class_type        entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == FULL_COUNT);
   assign valid = (count_ff != '0);
   assign head_item = entries_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Store pushed items
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue occupancy above depth");

   a_no_pop_empty : assert property (@(posedge clock) disable iff (reset)
      pop |-> valid)
      else $error("pop from empty queue");

   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into full queue");

endmodule

FILE: rtl/ctla_back.sv
// Back end: parses classified items and holds the result register.
module ctla_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  ctla_pkg::class_type item,
   output logic                item_take,
   output logic                empty,
   input  logic                pop,
   output ctla_pkg::rsp_type   rsp_item
);
   import ctla_pkg::*;

   logic [7:0]         call_ff [CALL_CHARS];
   logic [7:0]         call_in [CALL_CHARS];
   logic [7:0]         call_upd [CALL_CHARS];
   logic [COUNT_W-1:0] count_ff, count_in, count_upd;
   phase_type          phase_ff, phase_in, phase_upd;
   logic [4:0]         accum_ff, accum_in, accum_upd;
   logic               minus_ff, minus_in, minus_upd;
   logic               ended_ff, ended_in, ended_upd;
   logic               over_ff, over_in, over_upd;
   logic [7:0]         digit_sum;
   logic [4:0]         accum_next;
   logic               is_digit;
   logic               bad;
   rsp_type            result;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Take an item unless it must emit while the result register is occupied and not popped
   assign item_take = item_valid && (!item.is_last || !rsp_valid_ff || pop);
   assign empty = !rsp_valid_ff;
   assign rsp_item = rsp_ff;
   assign is_digit = (item.kind == KIND_DIGIT);

   // Accumulate one decimal digit, saturating just above the station limit
   assign digit_sum = {accum_ff, 3'b000} + {2'b00, accum_ff, 1'b0} + {4'b0000, item.digit};
   assign accum_next = (digit_sum > {3'b000, ACCUM_SAT}) ? ACCUM_SAT : digit_sum[4:0];

   // Next parse phase
   always_comb begin
      phase_upd = phase_ff;
      if (!ended_ff && item.kind != KIND_NUL) begin
         case (phase_ff)
            PH_CALL: begin
               if (item.kind == KIND_DASH) begin
                  phase_upd = PH_SPACE;
               end
            end
            PH_SPACE: begin
               if (item.kind inside {KIND_PLUS, KIND_DASH, KIND_DIGIT}) begin
                  phase_upd = PH_DIGITS;
               end else if (item.kind != KIND_WHITE) begin
                  phase_upd = PH_DONE;
               end
            end
            PH_DIGITS: begin
               if (!is_digit) begin
                  phase_upd = PH_DONE;
               end
            end
            default: begin
               phase_upd = phase_ff;
            end
         endcase
      end
   end

   // Update callsign, count, number and flags for the current item
   always_comb begin
      call_upd = call_ff;
      count_upd = count_ff;
      accum_upd = accum_ff;
      minus_upd = minus_ff;
      ended_upd = ended_ff;
      over_upd = over_ff;
      if (!ended_ff) begin
         if (item.kind == KIND_NUL) begin
            ended_upd = 1'b1;
            if (phase_ff == PH_CALL && count_ff == '0 && !over_ff) begin
               over_upd = 1'b1;
            end
         end else begin
            case (phase_ff)
               PH_CALL: begin
                  if (item.kind != KIND_DASH) begin
                     if (count_ff < COUNT_W'(CALL_CHARS)) begin
                        for (int i = 0; i < CALL_CHARS; i++) begin
                           if (count_ff == COUNT_W'(i)) begin
                              call_upd[i] = item.call_byte;
                           end
                        end
                        count_upd = count_ff + 1'b1;
                     end else begin
                        over_upd = 1'b1;
                     end
                  end
               end
               PH_SPACE: begin
                  if (item.kind == KIND_DASH) begin
                     minus_upd = 1'b1;
                  end else if (is_digit) begin
                     accum_upd = accum_next;
                  end
               end
               PH_DIGITS: begin
                  if (is_digit) begin
                     accum_upd = accum_next;
                  end
               end
               default: begin
                  accum_upd = accum_ff;
               end
            endcase
         end
      end
   end

   // Form the result from the updated state
   always_comb begin
      bad = over_upd || (accum_upd > STATION_MAX) || (minus_upd && accum_upd != '0) ||
            (!ended_upd && phase_upd == PH_CALL && count_upd == '0);
      result = '0;
      result.bad_text = bad;
      if (!bad) begin
         for (int i = 0; i < CALL_CHARS; i++) begin
            result.callsign_bytes[(CALL_CHARS - 1 - i) * 8 +: 8] = call_upd[i];
         end
         result.station_byte = STATION_BASE | {3'b000, accum_upd[3:0], 1'b0};
      end
   end

   // Commit the item; a last item restarts the parser
   always_comb begin
      call_in = call_ff;
      count_in = count_ff;
      phase_in = phase_ff;
      accum_in = accum_ff;
      minus_in = minus_ff;
      ended_in = ended_ff;
      over_in = over_ff;
      if (item_take) begin
         if (item.is_last) begin
            for (int i = 0; i < CALL_CHARS; i++) begin
               call_in[i] = PAD_BYTE;
            end
            count_in = '0;
            phase_in = PH_CALL;
            accum_in = '0;
            minus_in = 1'b0;
            ended_in = 1'b0;
            over_in = 1'b0;
         end else begin
            call_in = call_upd;
            count_in = count_upd;
            phase_in = phase_upd;
            accum_in = accum_upd;
            minus_in = minus_upd;
            ended_in = ended_upd;
            over_in = over_upd;
         end
      end
   end

   // Load the result register or drain it
   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (item_take && item.is_last) begin
         rsp_in = result;
         rsp_valid_in = 1'b1;
      end else if (pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CALL_CHARS; i++) begin
            call_ff[i] <= PAD_BYTE;
         end
         count_ff <= '0;
         phase_ff <= PH_CALL;
         accum_ff <= '0;
         minus_ff <= 1'b0;
         ended_ff <= 1'b0;
         over_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         call_ff <= call_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         minus_ff <= minus_in;
         ended_ff <= ended_in;
         over_ff <= over_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_restart : assert property (@(posedge clock) disable iff (reset)
      (item_take && item.is_last) |=>
      (count_ff == '0 && phase_ff == PH_CALL && !ended_ff && !over_ff && accum_ff == '0))
      else $error("parser not restarted after last item");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CALL_CHARS))
      else $error("callsign count above limit");

   a_bad_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.bad_text) |->
      (rsp_ff.callsign_bytes == '0 && rsp_ff.station_byte == '0))
      else $error("error result carries payload");

   a_good_station : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.bad_text) |-> (rsp_ff.station_byte[7:5] == 3'b011 &&
      !rsp_ff.station_byte[0]))
      else $error("station byte malformed");

   a_accum_bound : assert property (@(posedge clock) disable iff (reset)
      accum_ff <= ACCUM_SAT)
      else $error("station number above saturation");

endmodule

FILE: rtl/callsign_to_link_address.sv
// Top level of the callsign to link-address encoder.
//
// Input channel: one text character per item on req_item (char_code, is_last),
// written with push while full is low. A NUL ends the text; the item with
// is_last set closes it and produces exactly one result.
// Result channel: while empty is low, rsp_item holds the six shifted callsign
// bytes, the station byte 0x60 | (number << 1) and bad_text; pop takes it.
// Items that are not last produce no result.
// A closing item passes through the queue entry and then the result register
// before it shows on rsp_item. Throughput: one item per cycle, set by the
// parser update in the back end, while no closing item waits for the result
// register. A small queue (QUEUE_DEPTH items) decouples the classifier from
// the parser, and one result register decouples the parser from the reader.
// Reset (synchronous) empties the queue and the result register and returns
// the parser to the start of a callsign. When the reader stalls, a closing
// item waits in the parser while non-closing items keep being absorbed; once
// the queue fills, full rises and stays high until a result is popped.
module callsign_to_link_address #(
   parameter int unsigned QUEUE_DEPTH = ctla_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  ctla_pkg::req_type req_item,
   output logic              empty,
   input  logic              pop,
   output ctla_pkg::rsp_type rsp_item
);
   import ctla_pkg::*;

   logic      queue_push;
   logic      queue_full;
   logic      queue_valid;
   logic      queue_pop;
   class_type front_item;
   class_type head_item;

   // Classify incoming characters
   ctla_front u_front (
      .req_item   (req_item),
      .push       (push),
      .queue_full (queue_full),
      .full       (full),
      .queue_push (queue_push),
      .queue_item (front_item)
   );

   // Buffer classified items
   ctla_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .valid     (queue_valid),
      .head_item (head_item)
   );

   // Parse and emit results
   ctla_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item       (head_item),
      .item_take  (queue_pop),
      .empty      (empty),
      .pop        (pop),
      .rsp_item   (rsp_item)
   );

endmodule
